@@ design/topic_count_histogram_assert.svh @@
// Assertion macros for the count histogram block
`ifndef TOPIC_COUNT_HISTOGRAM_ASSERT_SVH
`define TOPIC_COUNT_HISTOGRAM_ASSERT_SVH

// same-cycle implication, clocked on clk_i, held off during reset
`define TCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tch_pkg;

  localparam int unsigned MAX_DOCS   = 256;
  localparam int unsigned MAX_TOPICS = 32;
  localparam int unsigned MAX_VOCAB  = 2048;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned DOC_BITS   = 8;
  localparam int unsigned TOPIC_BITS = 5;
  localparam int unsigned WORD_BITS  = 11;
  localparam int unsigned ACT_BITS   = 2;

  localparam int unsigned DT_ADDR_BITS = DOC_BITS + TOPIC_BITS;
  localparam int unsigned TW_ADDR_BITS = TOPIC_BITS + WORD_BITS;

  localparam int unsigned DOCS_CFG_BITS   = 9;
  localparam int unsigned TOPICS_CFG_BITS = 6;
  localparam int unsigned VOCAB_CFG_BITS  = 12;
  localparam int unsigned CFG_DATA_BITS   = 12;
  localparam int unsigned CFG_IDX_BITS    = 2;

  localparam int unsigned IN_DATA_BITS  = 24;
  localparam int unsigned OUT_DATA_BITS = 32;
  localparam int unsigned OUT_USER_BITS = 2;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_COUNT  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_IGNORE = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DOCS   = 2'd0,
    CFG_TOPICS = 2'd1,
    CFG_VOCAB  = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_RMW,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic accept;
    logic sweep_start;
    logic sweep_run;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic out_free;
    logic in_clear;
  } sts_t;

endpackage

`default_nettype wire

@@ design/tch_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tch_ram #(
  parameter int unsigned ADDR_BITS = 13,
  parameter int unsigned DATA_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [DATA_BITS-1:0] wdata_i,
  input  wire logic                 re_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem_q [2**ADDR_BITS];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/tch_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tch_datapath import tch_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic [ACT_BITS-1:0]      in_user_i,
  input  wire logic [IN_DATA_BITS-1:0]  in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [OUT_DATA_BITS-1:0]      out_data_o,
  output logic [OUT_USER_BITS-1:0]      out_user_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [DOCS_CFG_BITS-1:0]   docs_q;
  logic [TOPICS_CFG_BITS-1:0] topics_q;
  logic [VOCAB_CFG_BITS-1:0]  vocab_q;
  logic [DOCS_CFG_BITS-1:0]   nd;
  logic [TOPICS_CFG_BITS-1:0] nt;
  logic [VOCAB_CFG_BITS-1:0]  nv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      docs_q   <= DOCS_CFG_BITS'(MAX_DOCS);
      topics_q <= TOPICS_CFG_BITS'(MAX_TOPICS);
      vocab_q  <= VOCAB_CFG_BITS'(MAX_VOCAB);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DOCS:   docs_q   <= cfg_data_i[DOCS_CFG_BITS-1:0];
        CFG_TOPICS: topics_q <= cfg_data_i[TOPICS_CFG_BITS-1:0];
        CFG_VOCAB:  vocab_q  <= cfg_data_i[VOCAB_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign nd = (docs_q > DOCS_CFG_BITS'(MAX_DOCS)) ? DOCS_CFG_BITS'(MAX_DOCS) : docs_q;
  assign nt = (topics_q > TOPICS_CFG_BITS'(MAX_TOPICS)) ?
              TOPICS_CFG_BITS'(MAX_TOPICS) : topics_q;
  assign nv = (vocab_q > VOCAB_CFG_BITS'(MAX_VOCAB)) ? VOCAB_CFG_BITS'(MAX_VOCAB) : vocab_q;

  logic [DOC_BITS-1:0]   in_doc;
  logic [TOPIC_BITS-1:0] in_topic;
  logic [WORD_BITS-1:0]  in_word;
  logic                  in_err;

  assign in_doc   = in_data_i[DOC_BITS-1:0];
  assign in_topic = in_data_i[DOC_BITS+TOPIC_BITS-1:DOC_BITS];
  assign in_word  = in_data_i[DOC_BITS+TOPIC_BITS+WORD_BITS-1:DOC_BITS+TOPIC_BITS];
  assign in_err   = ({1'b0, in_doc} >= nd) || ({1'b0, in_topic} >= nt) ||
                    ({1'b0, in_word} >= nv);

  action_e                 act_q;
  logic                    err_q;
  logic [DT_ADDR_BITS-1:0] dt_addr_q;
  logic [TW_ADDR_BITS-1:0] tw_addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q     <= action_e'(in_user_i);
      err_q     <= in_err;
      dt_addr_q <= {in_doc, in_topic};
      tw_addr_q <= {in_topic, in_word};
    end
  end

  // clearing sweep over both tables
  logic                       full_q;
  logic                       dt_done_q;
  logic                       tw_done_q;
  logic [DOC_BITS-1:0]        sw_d_q;
  logic [TOPIC_BITS-1:0]      sw_t_q;
  logic [TOPIC_BITS-1:0]      sw_k_q;
  logic [WORD_BITS-1:0]       sw_w_q;
  logic [DOCS_CFG_BITS-1:0]   lim_d;
  logic [TOPICS_CFG_BITS-1:0] lim_t;
  logic [VOCAB_CFG_BITS-1:0]  lim_v;
  logic                       dt_sweep_we;
  logic                       tw_sweep_we;

  assign lim_d = full_q ? DOCS_CFG_BITS'(MAX_DOCS) : nd;
  assign lim_t = full_q ? TOPICS_CFG_BITS'(MAX_TOPICS) : nt;
  assign lim_v = full_q ? VOCAB_CFG_BITS'(MAX_VOCAB) : nv;
  assign dt_sweep_we = cmd_i.sweep_run && !dt_done_q;
  assign tw_sweep_we = cmd_i.sweep_run && !tw_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q    <= 1'b1;
      dt_done_q <= 1'b0;
      tw_done_q <= 1'b0;
      sw_d_q    <= '0;
      sw_t_q    <= '0;
      sw_k_q    <= '0;
      sw_w_q    <= '0;
    end else if (cmd_i.sweep_start) begin
      full_q    <= 1'b0;
      dt_done_q <= (nd == '0) || (nt == '0);
      tw_done_q <= (nt == '0) || (nv == '0);
      sw_d_q    <= '0;
      sw_t_q    <= '0;
      sw_k_q    <= '0;
      sw_w_q    <= '0;
    end else begin
      if (dt_sweep_we) begin
        if (({1'b0, sw_t_q} + TOPICS_CFG_BITS'(1)) == lim_t) begin
          sw_t_q <= '0;
          if (({1'b0, sw_d_q} + DOCS_CFG_BITS'(1)) == lim_d) begin
            dt_done_q <= 1'b1;
          end else begin
            sw_d_q <= sw_d_q + DOC_BITS'(1);
          end
        end else begin
          sw_t_q <= sw_t_q + TOPIC_BITS'(1);
        end
      end
      if (tw_sweep_we) begin
        if (({1'b0, sw_w_q} + VOCAB_CFG_BITS'(1)) == lim_v) begin
          sw_w_q <= '0;
          if (({1'b0, sw_k_q} + TOPICS_CFG_BITS'(1)) == lim_t) begin
            tw_done_q <= 1'b1;
          end else begin
            sw_k_q <= sw_k_q + TOPIC_BITS'(1);
          end
        end else begin
          sw_w_q <= sw_w_q + WORD_BITS'(1);
        end
      end
    end
  end

  // read-modify-write of the addressed entries
  logic [COUNT_BITS-1:0]   dt_rd;
  logic [COUNT_BITS-1:0]   tw_rd;
  logic                    dt_full;
  logic                    tw_full;
  logic [COUNT_BITS-1:0]   dt_inc;
  logic [COUNT_BITS-1:0]   tw_inc;
  logic                    is_count;
  logic                    is_read;
  logic [COUNT_BITS-1:0]   res_dt;
  logic [COUNT_BITS-1:0]   res_tw;
  logic                    res_held;
  logic                    rmw_we;
  logic                    dt_we;
  logic                    tw_we;
  logic [DT_ADDR_BITS-1:0] dt_waddr;
  logic [TW_ADDR_BITS-1:0] tw_waddr;
  logic [COUNT_BITS-1:0]   dt_wdata;
  logic [COUNT_BITS-1:0]   tw_wdata;

  assign dt_full  = (dt_rd == COUNT_MAX);
  assign tw_full  = (tw_rd == COUNT_MAX);
  assign dt_inc   = dt_full ? dt_rd : dt_rd + COUNT_BITS'(1);
  assign tw_inc   = tw_full ? tw_rd : tw_rd + COUNT_BITS'(1);
  assign is_count = (act_q == ACT_COUNT) && !err_q;
  assign is_read  = (act_q == ACT_READ) && !err_q;
  assign res_dt   = is_count ? dt_inc : (is_read ? dt_rd : '0);
  assign res_tw   = is_count ? tw_inc : (is_read ? tw_rd : '0);
  assign res_held = is_count && (dt_full || tw_full);
  assign rmw_we   = cmd_i.out_load && is_count;

  assign dt_we    = dt_sweep_we || rmw_we;
  assign tw_we    = tw_sweep_we || rmw_we;
  assign dt_waddr = dt_sweep_we ? {sw_d_q, sw_t_q} : dt_addr_q;
  assign tw_waddr = tw_sweep_we ? {sw_k_q, sw_w_q} : tw_addr_q;
  assign dt_wdata = dt_sweep_we ? '0 : dt_inc;
  assign tw_wdata = tw_sweep_we ? '0 : tw_inc;

  tch_ram #(
    .ADDR_BITS(DT_ADDR_BITS),
    .DATA_BITS(COUNT_BITS)
  ) u_dt_ram (
    .clk_i  (clk_i),
    .we_i   (dt_we),
    .waddr_i(dt_waddr),
    .wdata_i(dt_wdata),
    .re_i   (cmd_i.accept),
    .raddr_i({in_doc, in_topic}),
    .rdata_o(dt_rd)
  );

  tch_ram #(
    .ADDR_BITS(TW_ADDR_BITS),
    .DATA_BITS(COUNT_BITS)
  ) u_tw_ram (
    .clk_i  (clk_i),
    .we_i   (tw_we),
    .waddr_i(tw_waddr),
    .wdata_i(tw_wdata),
    .re_i   (cmd_i.accept),
    .raddr_i({in_topic, in_word}),
    .rdata_o(tw_rd)
  );

  // output register
  logic                     out_valid_q;
  logic [OUT_DATA_BITS-1:0] out_data_q;
  logic [OUT_USER_BITS-1:0] out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {res_tw, res_dt};
      out_user_q <= {res_held, err_q && ((act_q == ACT_COUNT) || (act_q == ACT_READ))};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  assign sts_o.sweep_done = dt_done_q && tw_done_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.in_clear   = (action_e'(in_user_i) == ACT_CLEAR);

endmodule

`default_nettype wire

@@ design/tch_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tch_ctrl import tch_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep_run = !sts_i.sweep_done;
        if (sts_i.sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.in_clear) begin
            cmd_o.sweep_start = 1'b1;
            state_d           = ST_CLEAR;
          end else begin
            state_d = ST_RMW;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep_run = !sts_i.sweep_done;
        if (sts_i.sweep_done) begin
          state_d = ST_RMW;
        end
      end
      ST_RMW: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/topic_count_histogram.sv @@
// Count tables for a topic-model sampler: document-by-topic and topic-by-word.
// Input stream: tuser carries the action (count, read, clear, ignore), tdata the
// document, topic and word indices. Output stream: one transfer per input,
// tdata the two counts, tuser the index-error and saturation flags.
// Sizes in use are set through the write port; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// A count or read item goes through a registered read of both table RAMs,
// then the increment and write-back through the single write port of each
// RAM. The next item is accepted only after the result has been loaded.
// A clear item sweeps the in-use region, one entry of each table per cycle,
// ahead of its result. After reset both tables are zeroed by the same sweep
// over their full depth, during which no item is accepted; the sizes return
// to 256 documents, 32 topics and 2048 words.
// The output register holds a result while the receiver stalls and the next
// item is still accepted; its result waits in the write-back stage until
// the output register is free.
`timescale 1ns / 1ps
`default_nettype none

`include "topic_count_histogram_assert.svh"

module topic_count_histogram import tch_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // doc_index, topic_index, word_index
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // action
  input  wire logic [ACT_BITS-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // doc_topic_count, topic_word_count
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
  // index_error, saturated
  output logic [OUT_USER_BITS-1:0]      m_axis_tuser
);

  cmd_t cmd;
  sts_t sts;

  tch_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tch_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_user_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

  `TCH_ASSERT_NOW(a_ready_after_sweep, s_axis_tready, sts.sweep_done, "ready during sweep")
  `TCH_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "overlap")
  `TCH_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "err data")
  `TCH_ASSERT_NOW(a_sat_max, m_axis_tvalid && m_axis_tuser[1],
                  !m_axis_tuser[0] && ((&m_axis_tdata[15:0]) || (&m_axis_tdata[31:16])),
                  "saturation without max")

endmodule

`default_nettype wire

@@ dv/topic_count_histogram_test.sv @@
`timescale 1ns / 1ps

module topic_count_histogram_test;
  import tch_pkg::*;

  typedef struct packed {
    logic [COUNT_BITS-1:0] dt_count;
    logic [COUNT_BITS-1:0] tw_count;
    logic                  index_err;
    logic                  held;
  } tally_t;

  class histogram_shadow;
    bit [COUNT_BITS-1:0] dt_tab [MAX_DOCS*MAX_TOPICS];
    bit [COUNT_BITS-1:0] tw_tab [MAX_TOPICS*MAX_VOCAB];
    int unsigned docs_sz   = 256;
    int unsigned topics_sz = 32;
    int unsigned vocab_sz  = 2048;
    tally_t      pending_q[$];
    int unsigned errors;

    function int unsigned span(int unsigned value, int unsigned limit);
      return (value > limit) ? limit : value;
    endfunction

    function void set_size(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        CFG_DOCS:   docs_sz   = 32'(value[DOCS_CFG_BITS-1:0]);
        CFG_TOPICS: topics_sz = 32'(value[TOPICS_CFG_BITS-1:0]);
        CFG_VOCAB:  vocab_sz  = 32'(value[VOCAB_CFG_BITS-1:0]);
        default: ;
      endcase
    endfunction

    function void apply_item(action_e act, logic [DOC_BITS-1:0] d,
                             logic [TOPIC_BITS-1:0] t, logic [WORD_BITS-1:0] w);
      tally_t      r;
      int unsigned nd, nt, nv, a, b;
      r  = '0;
      nd = span(docs_sz, MAX_DOCS);
      nt = span(topics_sz, MAX_TOPICS);
      nv = span(vocab_sz, MAX_VOCAB);
      case (act)
        ACT_CLEAR: begin
          for (int unsigned i = 0; i < nd; i++)
            for (int unsigned k = 0; k < nt; k++)
              dt_tab[i*MAX_TOPICS+k] = '0;
          for (int unsigned k = 0; k < nt; k++)
            for (int unsigned i = 0; i < nv; i++)
              tw_tab[k*MAX_VOCAB+i] = '0;
        end
        ACT_IGNORE: ;
        default: begin
          if (d >= nd || t >= nt || w >= nv) begin
            r.index_err = 1'b1;
          end else begin
            a = d * MAX_TOPICS + t;
            b = t * MAX_VOCAB + w;
            if (act == ACT_COUNT) begin
              // hold a full count, bump the other entry regardless
              if (dt_tab[a] == '1) r.held = 1'b1;
              else dt_tab[a] = dt_tab[a] + 1'b1;
              if (tw_tab[b] == '1) r.held = 1'b1;
              else tw_tab[b] = tw_tab[b] + 1'b1;
            end
            r.dt_count = dt_tab[a];
            r.tw_count = tw_tab[b];
          end
        end
      endcase
      pending_q.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task take_result(logic [OUT_DATA_BITS-1:0] data, logic [OUT_USER_BITS-1:0] user);
      tally_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("transfer with no result due, tdata %h tuser %b", data, user));
        return;
      end
      want = pending_q.pop_front();
      if (data[COUNT_BITS-1:0] !== want.dt_count)
        report($sformatf("doc_topic_count %0d, want %0d", data[COUNT_BITS-1:0], want.dt_count));
      if (data[2*COUNT_BITS-1:COUNT_BITS] !== want.tw_count)
        report($sformatf("topic_word_count %0d, want %0d",
                         data[2*COUNT_BITS-1:COUNT_BITS], want.tw_count));
      if (user[0] !== want.index_err)
        report($sformatf("index_error %b, want %b", user[0], want.index_err));
      if (user[1] !== want.held)
        report($sformatf("saturated %b, want %b", user[1], want.held));
    endtask
  endclass

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic [ACT_BITS-1:0]      s_axis_tuser  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic [OUT_USER_BITS-1:0] m_axis_tuser;

  bit              steady = 1'b0;
  histogram_shadow shadow = new();

  always #1 clk_i = ~clk_i;

  topic_count_histogram u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      shadow.take_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin : sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 19);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_item(action_e act, logic [DOC_BITS-1:0] d,
                           logic [TOPIC_BITS-1:0] t, logic [WORD_BITS-1:0] w);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, t, d};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.apply_item(act, d, t, w);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.set_size(idx, value);
  endtask

  // drop valid and drain every outstanding result
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (shadow.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned              made, phase_len, nd, nt, nv, pick, lim;
    logic [CFG_DATA_BITS-1:0] v;
    logic [DOC_BITS-1:0]      d;
    logic [TOPIC_BITS-1:0]    t;
    logic [WORD_BITS-1:0]     w;
    action_e                  act;
    bit                       clear_ok;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(ACT_READ, '0, '0, '0);
    send_item(ACT_COUNT, '0, '0, '0);
    send_item(ACT_COUNT, '1, '1, '1);
    send_item(ACT_COUNT, '1, '1, '0);
    send_item(ACT_READ, '1, '1, '1);
    send_item(ACT_IGNORE, '1, '1, '1);
    send_item(ACT_COUNT, '0, '0, '0);
    send_item(ACT_CLEAR, 8'h5a, 5'h15, 11'h2a5);
    send_item(ACT_READ, '0, '0, '0);
    send_item(ACT_READ, '1, '1, '1);
    settle();
    write_reg(CFG_DOCS, 12'd1);
    write_reg(CFG_TOPICS, 12'd1);
    write_reg(CFG_VOCAB, 12'd1);
    send_item(ACT_COUNT, '0, '0, '0);
    send_item(ACT_COUNT, 8'd1, '0, '0);
    send_item(ACT_READ, '0, 5'd1, '0);
    send_item(ACT_COUNT, '0, '0, 11'd1);
    settle();
    write_reg(CFG_DOCS, 12'd0);
    send_item(ACT_COUNT, '0, '0, '0);
    send_item(ACT_CLEAR, '0, '0, '0);
    settle();
    write_reg(CFG_DOCS, 12'd1);
    send_item(ACT_READ, '0, '0, '0);
    settle();
    write_reg(CFG_DOCS, '1);
    write_reg(CFG_TOPICS, '1);
    write_reg(CFG_VOCAB, '1);
    write_reg(CFG_SPARE, '1);
    send_item(ACT_COUNT, '1, '1, '1);
    settle();
    write_reg(CFG_DOCS, 12'd2);
    send_item(ACT_READ, '1, '1, '1);
    settle();
    write_reg(CFG_DOCS, 12'd256);
    send_item(ACT_READ, '1, '1, '1);

    // back to back counts on one entry pair
    settle();
    write_reg(CFG_DOCS, 12'd2);
    write_reg(CFG_TOPICS, 12'd1);
    write_reg(CFG_VOCAB, 12'd2);
    steady = 1'b1;
    repeat (16) send_item(ACT_COUNT, '0, '0, '0);
    send_item(ACT_COUNT, 8'd1, '0, '0);
    send_item(ACT_COUNT, '0, '0, 11'd1);
    send_item(ACT_READ, '0, '0, '0);
    send_item(ACT_CLEAR, '0, '0, '0);
    send_item(ACT_READ, '0, '0, '0);

    made = 0;
    while (made < 1400) begin
      settle();
      v = CFG_DATA_BITS'($urandom);
      case ($urandom_range(0, 7))
        0: v[DOCS_CFG_BITS-1:0] = DOCS_CFG_BITS'(1);
        1: v[DOCS_CFG_BITS-1:0] = DOCS_CFG_BITS'(MAX_DOCS);
        2: v[DOCS_CFG_BITS-1:0] = DOCS_CFG_BITS'(0);
        3: v[DOCS_CFG_BITS-1:0] = DOCS_CFG_BITS'($urandom_range(MAX_DOCS + 1, 511));
        4: v[DOCS_CFG_BITS-1:0] = DOCS_CFG_BITS'($urandom_range(1, MAX_DOCS));
        default: v[DOCS_CFG_BITS-1:0] = DOCS_CFG_BITS'($urandom_range(1, 16));
      endcase
      write_reg(CFG_DOCS, v);
      v = CFG_DATA_BITS'($urandom);
      case ($urandom_range(0, 7))
        0: v[TOPICS_CFG_BITS-1:0] = TOPICS_CFG_BITS'(1);
        1: v[TOPICS_CFG_BITS-1:0] = TOPICS_CFG_BITS'(MAX_TOPICS);
        2: v[TOPICS_CFG_BITS-1:0] = TOPICS_CFG_BITS'(0);
        3: v[TOPICS_CFG_BITS-1:0] = TOPICS_CFG_BITS'($urandom_range(MAX_TOPICS + 1, 63));
        4: v[TOPICS_CFG_BITS-1:0] = TOPICS_CFG_BITS'($urandom_range(1, MAX_TOPICS));
        default: v[TOPICS_CFG_BITS-1:0] = TOPICS_CFG_BITS'($urandom_range(1, 8));
      endcase
      write_reg(CFG_TOPICS, v);
      v = CFG_DATA_BITS'($urandom);
      case ($urandom_range(0, 7))
        0: v = CFG_DATA_BITS'(1);
        1: v = CFG_DATA_BITS'(MAX_VOCAB);
        2: v = CFG_DATA_BITS'(0);
        3: v = CFG_DATA_BITS'($urandom_range(MAX_VOCAB + 1, 4095));
        4: v = CFG_DATA_BITS'($urandom_range(1, MAX_VOCAB));
        default: v = CFG_DATA_BITS'($urandom_range(1, 64));
      endcase
      write_reg(CFG_VOCAB, v);
      if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));

      nd = shadow.span(shadow.docs_sz, MAX_DOCS);
      nt = shadow.span(shadow.topics_sz, MAX_TOPICS);
      nv = shadow.span(shadow.vocab_sz, MAX_VOCAB);
      clear_ok  = (nd * nt <= 4096) && (nt * nv <= 4096);
      steady    = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(20, 120);

      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) act = ACT_IGNORE;
        else if (pick < 5 && clear_ok) act = ACT_CLEAR;
        else if (pick < 35) act = ACT_READ;
        else act = ACT_COUNT;
        d = DOC_BITS'($urandom);
        t = TOPIC_BITS'($urandom);
        w = WORD_BITS'($urandom);
        // keep most items in range and on a few hot entries so counts build up
        if ($urandom_range(0, 9) != 0 && nd > 0 && nt > 0 && nv > 0) begin
          lim = (nd < 4) ? nd : 4;
          d = ($urandom_range(0, 1) == 0) ? DOC_BITS'($urandom_range(0, lim - 1)) :
                                            DOC_BITS'($urandom_range(0, nd - 1));
          t = TOPIC_BITS'($urandom_range(0, nt - 1));
          lim = (nv < 8) ? nv : 8;
          w = ($urandom_range(0, 1) == 0) ? WORD_BITS'($urandom_range(0, lim - 1)) :
                                            WORD_BITS'($urandom_range(0, nv - 1));
        end
        send_item(act, d, t, w);
        if (act != ACT_IGNORE) made++;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < 200000 && shadow.pending_q.size() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (shadow.pending_q.size() != 0)
      shadow.report($sformatf("%0d results never arrived", shadow.pending_q.size()));

    if (shadow.errors == 0) begin
      $display("topic_count_histogram_test passed");
    end else begin
      $display("topic_count_histogram_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("topic_count_histogram_test failed");
    $finish;
  end

endmodule
